/* rtl/cubic_hermite_interpolator_core_defines.svh */
// ----------------------------------------------------------------------------
// cubic hermite interpolator core assertion macros
// same-cycle and next-cycle implication checks under asynchronous reset
// ----------------------------------------------------------------------------
`ifndef CUBIC_HERMITE_INTERPOLATOR_CORE_DEFINES_SVH
`define CUBIC_HERMITE_INTERPOLATOR_CORE_DEFINES_SVH

`define CHI_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

`define CHI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/chi_pkg.sv */
// ----------------------------------------------------------------------------
// chi_pkg
// widths, constants and the basis weight bundle of the hermite interpolator
// ----------------------------------------------------------------------------
`default_nettype none

package chi_pkg;

	localparam int TW  = 17;
	localparam int DW  = 32;
	localparam int WW  = 18;
	localparam int XW  = 52;
	localparam int TAGW = 3;

	localparam logic [TW-1:0] T_ONE = 17'd65536;
	localparam logic signed [XW-1:0] ONE_Q48 = 52'sd281474976710656;
	localparam logic signed [XW-1:0] HALF_Q32 = 52'sd2147483648;
	localparam logic [WW:0] W_ONE = 19'd65536;

	typedef logic signed [WW-1:0] weight_t;

	typedef struct packed {
		weight_t h00;
		weight_t h10;
		weight_t h01;
		weight_t h11;
	} weights_t;

endpackage

`default_nettype wire

/* rtl/chi_basis.sv */
// ----------------------------------------------------------------------------
// chi_basis
// three-stage hermite basis weight generator: t squared, t cubed, weights
// ----------------------------------------------------------------------------
`default_nettype none

module chi_basis (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [16:0]      t_in,
	output chi_pkg::weights_t     w
);
	import chi_pkg::*;

	logic [TW-1:0] tc;
	logic [2*TW-1:0] sq;
	logic [TW-1:0] t_s1;
	logic [2*TW-2:0] tt_s1;
	logic [3*TW-2:0] cube;
	logic [TW-1:0] t_s2;
	logic [2*TW-2:0] tt_s2;
	logic [3*TW-3:0] t3_s2;
	logic signed [XW-1:0] t1w, t2w, t3w;
	logic signed [XW-1:0] x00, x10, x01, x11;
	weights_t w_s3;

	function automatic weight_t rnd(input logic signed [XW-1:0] x);
		logic signed [XW-1:0] r;
		r = x + HALF_Q32;
		return $signed(r[WW+31:32]);
	endfunction

	// position beyond one clamps to one
	assign tc = (t_in > T_ONE) ? T_ONE : t_in;
	assign sq = {{TW{1'b0}}, tc} * {{TW{1'b0}}, tc};
	assign cube = {{TW{1'b0}}, tt_s1} * {{(2*TW-1){1'b0}}, t_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= tc;
			tt_s1 <= sq[2*TW-2:0];
			t_s2  <= t_s1;
			tt_s2 <= tt_s1;
			t3_s2 <= cube[3*TW-3:0];
			w_s3  <= '{h00: rnd(x00), h10: rnd(x10), h01: rnd(x01), h11: rnd(x11)};
		end
	end

	// powers of t in q.48
	assign t1w = $signed({3'b000, t_s2, 32'd0});
	assign t2w = $signed({3'b000, tt_s2, 16'd0});
	assign t3w = $signed({3'b000, t3_s2});

	assign x00 = (t3w <<< 1) - (t2w <<< 1) - t2w + ONE_Q48;
	assign x10 = t3w - (t2w <<< 1) + t1w;
	assign x01 = (t2w <<< 1) + t2w - (t3w <<< 1);
	assign x11 = t3w - t2w;

	assign w = w_s3;

endmodule

`default_nettype wire

/* rtl/cubic_hermite_interpolator_core.sv */
// ----------------------------------------------------------------------------
// cubic_hermite_interpolator_core
// accepted requests move through stages s1 to s6 to m_tvalid, one request per cycle
// while the output is not stalled; six-stage multiply/add pipeline, no bubbles
// a stall on the output side holds every stage; reset clears the valid bits
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_hermite_interpolator_core_defines.svh"

module cubic_hermite_interpolator_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// blend_t, start_value, start_tangent, end_value, end_tangent, zero pad
	input  wire logic [151:0] s_tdata,
	// channel_tag
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_value
	output logic [31:0]       m_tdata,
	// out_tag
	output logic [2:0]        m_tuser
);
	import chi_pkg::*;

	typedef struct packed {
		logic signed [DW-1:0] p0;
		logic signed [DW-1:0] m0;
		logic signed [DW-1:0] p1;
		logic signed [DW-1:0] m1;
		logic [TAGW-1:0]      tag;
	} ops_t;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	ops_t ops_in, ops_s1, ops_s2, ops_s3;
	weights_t w;
	logic signed [WW+DW-1:0] prod_s4 [4];
	logic [TAGW-1:0] tag_s4, tag_s5, tag_s6;
	logic signed [WW+DW:0] sum_a_s5, sum_b_s5;
	logic signed [XW-1:0] acc, acc_r;
	logic signed [XW-17:0] q;
	logic [DW-1:0] sat;
	logic [DW-1:0] out_value_s6;

	assign en = !valid_s6 || m_tready;
	assign s_tready = en;

	assign ops_in = '{
		p0:  $signed(s_tdata[48:17]),
		m0:  $signed(s_tdata[80:49]),
		p1:  $signed(s_tdata[112:81]),
		m1:  $signed(s_tdata[144:113]),
		tag: s_tuser
	};

	chi_basis u_basis (
		.clk    (clk),
		.en     (en),
		.t_in   (s_tdata[16:0]),
		.w      (w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// final sum, round half up to q16.16, saturate
	assign acc   = XW'(sum_a_s5) + XW'(sum_b_s5);
	assign acc_r = acc + 52'sd32768;
	assign q     = acc_r[XW-1:16];

	always_comb begin
		if (q[XW-17:DW-1] == '0 || q[XW-17:DW-1] == '1) begin
			sat = q[DW-1:0];
		end else if (q[XW-17]) begin
			sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ops_s1 <= ops_in;
			ops_s2 <= ops_s1;
			ops_s3 <= ops_s2;
			prod_s4[0] <= (WW+DW)'(w.h00) * (WW+DW)'(ops_s3.p0);
			prod_s4[1] <= (WW+DW)'(w.h10) * (WW+DW)'(ops_s3.m0);
			prod_s4[2] <= (WW+DW)'(w.h01) * (WW+DW)'(ops_s3.p1);
			prod_s4[3] <= (WW+DW)'(w.h11) * (WW+DW)'(ops_s3.m1);
			tag_s4 <= ops_s3.tag;
			sum_a_s5 <= (WW+DW+1)'(prod_s4[0]) + (WW+DW+1)'(prod_s4[1]);
			sum_b_s5 <= (WW+DW+1)'(prod_s4[2]) + (WW+DW+1)'(prod_s4[3]);
			tag_s5 <= tag_s4;
			out_value_s6 <= sat;
			tag_s6 <= tag_s5;
		end
	end

	assign m_tvalid = valid_s6;
	assign m_tdata  = out_value_s6;
	assign m_tuser  = tag_s6;

	`CHI_ASSERT_NEXT(a_stall_holds_valids, clk, arst_n, !en,
		$stable({valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6}),
		"pipeline valid bits moved during a stall")
	`CHI_ASSERT_NEXT(a_drain_empties, clk, arst_n, m_tvalid && m_tready && !valid_s5,
		!m_tvalid, "output valid without a request behind it")
	`CHI_ASSERT_NOW(a_weight_signs, clk, arst_n, valid_s3,
		!w.h10[WW-1] && !w.h00[WW-1] && !w.h01[WW-1] && (w.h11[WW-1] || w.h11 == '0),
		"basis weight with wrong sign")
	`CHI_ASSERT_NOW(a_weight_sum, clk, arst_n, valid_s3,
		((WW+1)'(w.h00) + (WW+1)'(w.h01) == W_ONE) ||
		((WW+1)'(w.h00) + (WW+1)'(w.h01) == W_ONE + 19'd1),
		"end weights do not add up to one")

endmodule

`default_nettype wire
